// ===== sv/bpa_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the bitmap page allocator.
// ---------------------------------------------------------------------------
package bpa_pkg;

    localparam int PAGE_W    = 16;
    localparam int CNT_W     = 17;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int MAX_PAGES = 65536;
    localparam int DEPTH     = MAX_PAGES / WORD_W;
    localparam int ADDR_W    = $clog2(DEPTH);

    localparam logic [CNT_W-1:0] MAX_PAGES_C = CNT_W'(MAX_PAGES);
    localparam logic [CNT_W-1:0] FREE_SAT    = '1;

    localparam logic [1:0] MODE_ALLOC     = 2'd0;
    localparam logic [1:0] MODE_FREE_ONE  = 2'd1;
    localparam logic [1:0] MODE_MARK_FREE = 2'd2;
    localparam logic [1:0] MODE_MARK_USED = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_RUN  = 2'd1;
    localparam logic [1:0] STATUS_IGNORED = 2'd2;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } ram_req_t;

endpackage

// ===== sv/bpa_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpa_ram
// Single-port bitmap store, one used bit per page, registered read data.
// ---------------------------------------------------------------------------
module bpa_ram (
    input  logic                          aclk,
    input  bpa_pkg::ram_req_t             req,
    output logic [bpa_pkg::WORD_W-1:0]    rdata
);

    logic [bpa_pkg::WORD_W-1:0] mem [bpa_pkg::DEPTH];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rdata <= mem[req.addr];
        end
    end

endmodule

// ===== sv/bitmap_page_allocator_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bitmap_page_allocator_unit
// Next-fit page allocator over a used/free bitmap held in one block RAM.
// ---------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  s_        in         s_tvalid/s_tready   tuser mode, tdata index/count
//  m_        out        m_tvalid/m_tready   tdata status/page/free count
//  cfg_      in         cfg_valid/cfg_ready cfg_data total_pages
//
// One item at a time. An allocation scans one page per cycle between word
// reads, with a RAM read before each 32-page word, then reads and writes
// back each page it claims. A free or range mark reads and writes back each
// page touched. After reset a clearing pass fills all 2048 bitmap words with
// ones, with s_tready low. A finished result waits in the output register;
// the unit takes the next item while it waits and stalls only when a second
// result would overwrite it.
// ---------------------------------------------------------------------------
module bitmap_page_allocator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // first_page[15:0], page_count[32:16], zero pad
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[1:0], result_page[17:2], free_count[34:18]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data   // total_pages
);

    typedef enum logic [7:0] {
        ST_CLEAR   = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_SCAN_RD = 8'b0000_0100,
        ST_SCAN    = 8'b0000_1000,
        ST_MARK_RD = 8'b0001_0000,
        ST_MARK_WR = 8'b0010_0000,
        ST_DONE    = 8'b0100_0000
    } state_t;

    localparam int CW = bpa_pkg::CNT_W;
    localparam int PW = bpa_pkg::PAGE_W;

    state_t                       state_reg, state_next;
    logic [bpa_pkg::ADDR_W-1:0]   clr_reg, clr_next;
    logic [CW-1:0]                page_reg, page_next;
    logic [CW-1:0]                hi_reg, hi_next;
    logic [CW-1:0]                want_reg, want_next;
    logic [CW-1:0]                run_reg, run_next;
    logic [PW-1:0]                rs_reg, rs_next;
    logic                         pass_reg, pass_next;
    logic [CW-1:0]                left_reg, left_next;
    logic                         set_used_reg, set_used_next;
    logic [PW-1:0]                ss_reg, ss_next;
    logic [CW-1:0]                free_reg, free_next;
    logic [CW-1:0]                total_reg;
    logic [1:0]                   status_reg, status_next;
    logic [PW-1:0]                rpage_reg, rpage_next;
    logic                         m_valid_reg, m_valid_next;
    logic [39:0]                  m_data_reg, m_data_next;

    bpa_pkg::ram_req_t            ram_req;
    logic [bpa_pkg::WORD_W-1:0]   ram_rdata;

    logic [CW-1:0]                cap;
    logic [CW-1:0]                ss_ext;
    logic [CW-1:0]                page_inc;
    logic [CW-1:0]                run_inc;
    logic [PW-1:0]                start;
    logic [CW-1:0]                run_end;
    logic                         cur_bit;
    logic [bpa_pkg::WORD_W-1:0]   bit_mask;
    logic [1:0]                   in_mode;
    logic [PW-1:0]                in_index;
    logic [CW-1:0]                in_count;

    bpa_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign in_mode  = s_tuser;
    assign in_index = s_tdata[15:0];
    assign in_count = s_tdata[32:16];

    assign cap      = (total_reg > bpa_pkg::MAX_PAGES_C) ? bpa_pkg::MAX_PAGES_C : total_reg;
    assign ss_ext   = {1'b0, ss_reg};
    assign page_inc = page_reg + CW'(1);
    assign run_inc  = run_reg + CW'(1);
    assign start    = (run_reg == '0) ? page_reg[PW-1:0] : rs_reg;
    assign run_end  = {1'b0, start} + want_reg;
    assign cur_bit  = ram_rdata[page_reg[bpa_pkg::BIT_W-1:0]];
    assign bit_mask = bpa_pkg::WORD_W'(1) << page_reg[bpa_pkg::BIT_W-1:0];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        page_next     = page_reg;
        hi_next       = hi_reg;
        want_next     = want_reg;
        run_next      = run_reg;
        rs_next       = rs_reg;
        pass_next     = pass_reg;
        left_next     = left_reg;
        set_used_next = set_used_reg;
        ss_next       = ss_reg;
        free_next     = free_reg;
        status_next   = status_reg;
        rpage_next    = rpage_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        ram_req       = '0;
        ram_req.addr  = page_reg[PW-1:bpa_pkg::BIT_W];

        case (state_reg)
            ST_CLEAR: begin
                // fill every word with ones: every page starts used
                ram_req.wr_en = 1'b1;
                ram_req.addr  = clr_reg;
                ram_req.wdata = '1;
                clr_next      = clr_reg + bpa_pkg::ADDR_W'(1);
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    status_next = bpa_pkg::STATUS_OK;
                    rpage_next  = '0;
                    case (in_mode)
                        bpa_pkg::MODE_ALLOC: begin
                            if (in_count == '0) begin
                                status_next = bpa_pkg::STATUS_IGNORED;
                                state_next  = ST_DONE;
                            end else if (cap == '0 || in_count > cap) begin
                                status_next = bpa_pkg::STATUS_NO_RUN;
                                state_next  = ST_DONE;
                            end else begin
                                // first pass: pointer up to capacity
                                page_next  = ss_ext;
                                hi_next    = cap;
                                pass_next  = 1'b0;
                                run_next   = '0;
                                want_next  = in_count;
                                state_next = ST_SCAN_RD;
                            end
                        end
                        bpa_pkg::MODE_FREE_ONE: begin
                            if (in_index == '0 || {1'b0, in_index} >= cap) begin
                                status_next = bpa_pkg::STATUS_IGNORED;
                                state_next  = ST_DONE;
                            end else begin
                                if (in_index < ss_reg) begin
                                    ss_next = in_index;
                                end
                                page_next     = {1'b0, in_index};
                                left_next     = CW'(1);
                                set_used_next = 1'b0;
                                state_next    = ST_MARK_RD;
                            end
                        end
                        default: begin
                            page_next     = {1'b0, in_index};
                            left_next     = in_count;
                            set_used_next = (in_mode == bpa_pkg::MODE_MARK_USED);
                            state_next    = ST_MARK_RD;
                        end
                    endcase
                end
            end
            ST_SCAN_RD: begin
                if (page_reg >= hi_reg) begin
                    if (!pass_reg) begin
                        // second pass: page 0 up to the pointer
                        pass_next = 1'b1;
                        page_next = '0;
                        hi_next   = (ss_ext < cap) ? ss_ext : cap;
                        run_next  = '0;
                    end else begin
                        status_next = bpa_pkg::STATUS_NO_RUN;
                        state_next  = ST_DONE;
                    end
                end else begin
                    ram_req.rd_en = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!cur_bit && run_inc == want_reg) begin
                    // run found: claim it and move the pointer past it
                    ss_next       = (run_end == cap) ? '0 : run_end[PW-1:0];
                    rpage_next    = start;
                    page_next     = {1'b0, start};
                    left_next     = want_reg;
                    set_used_next = 1'b1;
                    state_next    = ST_MARK_RD;
                end else begin
                    if (cur_bit) begin
                        run_next = '0;
                    end else begin
                        run_next = run_inc;
                        rs_next  = start;
                    end
                    page_next = page_inc;
                    if (page_inc >= hi_reg || page_reg[bpa_pkg::BIT_W-1:0] == '1) begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_MARK_RD: begin
                if (left_reg == '0 || page_reg >= cap) begin
                    state_next = ST_DONE;
                end else begin
                    ram_req.rd_en = 1'b1;
                    state_next    = ST_MARK_WR;
                end
            end
            ST_MARK_WR: begin
                ram_req.wr_en = 1'b1;
                if (set_used_reg) begin
                    ram_req.wdata = ram_rdata | bit_mask;
                    if (!cur_bit && free_reg != '0) begin
                        free_next = free_reg - CW'(1);
                    end
                end else begin
                    ram_req.wdata = ram_rdata & ~bit_mask;
                    if (cur_bit && free_reg != bpa_pkg::FREE_SAT) begin
                        free_next = free_reg + CW'(1);
                    end
                end
                page_next  = page_inc;
                left_next  = left_reg - CW'(1);
                state_next = ST_MARK_RD;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'd0, free_reg, rpage_reg, status_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            ss_reg      <= '0;
            free_reg    <= '0;
            total_reg   <= bpa_pkg::MAX_PAGES_C;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            ss_reg      <= ss_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                total_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        page_reg     <= page_next;
        hi_reg       <= hi_next;
        want_reg     <= want_next;
        run_reg      <= run_next;
        rs_reg       <= rs_next;
        pass_reg     <= pass_next;
        left_reg     <= left_next;
        set_used_reg <= set_used_next;
        status_reg   <= status_next;
        rpage_reg    <= rpage_next;
        m_data_reg   <= m_data_next;
    end

endmodule
